// ===== hw/rtl/set_assoc_cache_fifo_tags_core_macros.svh =====
// assertion macros for the set associative cache tag core
// used by the top level only; expects clk and arst_n in scope
`ifndef SET_ASSOC_CACHE_FIFO_TAGS_CORE_MACROS_SVH
`define SET_ASSOC_CACHE_FIFO_TAGS_CORE_MACROS_SVH

// same-cycle implication
`define SACF_ASSERT_NOW(lbl, ante, cons, msg) lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SACF_ASSERT_NEXT(lbl, ante, cons, msg) lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/sacf_pkg.sv =====
// shared types, constants and helpers of the cache tag core
// no dependencies
package sacf_pkg;

	localparam int ADDR_W  = 64;
	localparam int BYTES_W = 7;
	localparam int CNT_W   = 48;
	localparam int QDEPTH  = 2;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  address;
		logic               operation;
		logic [BYTES_W-1:0] access_bytes;
	} req_t;

	typedef struct packed {
		logic              hit;
		logic              writeback_valid;
		logic [ADDR_W-1:0] writeback_address;
		logic [ADDR_W-1:0] fill_address;
		cnt_t              read_accesses_total;
		cnt_t              write_accesses_total;
		cnt_t              read_misses_total;
		cnt_t              write_misses_total;
		cnt_t              bytes_read_total;
		cnt_t              bytes_written_total;
		cnt_t              writebacks_total;
	} rsp_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_LOOKUP
	} back_state_t;

	function automatic cnt_t sat_add(cnt_t a, logic [BYTES_W-1:0] b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {{(CNT_W + 1 - BYTES_W){1'b0}}, b};
		return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
	endfunction

endpackage

// ===== hw/rtl/sacf_front.sv =====
// front end: takes access beats and holds them in a short queue
// depends on sacf_pkg
module sacf_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  sacf_pkg::req_t req,
	output logic          q_valid,
	input  logic          q_pop,
	output sacf_pkg::req_t q_head
);
	import sacf_pkg::*;

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	req_t          fifo_q [QDEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push;

	assign req_stall = (count_q == CW'(QDEPTH));
	assign push      = req_valid && !req_stall;
	assign q_valid   = (count_q != '0);
	assign q_head    = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, q_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= req;
		end
	end

endmodule

// ===== hw/rtl/sacf_back.sv =====
// back end: set row memory, tag compare, fifo replacement, counters, result register
// depends on sacf_pkg
module sacf_back #(
	parameter int SETS       = 64,
	parameter int WAYS       = 4,
	parameter int LINE_BYTES = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	output logic           q_pop,
	input  sacf_pkg::req_t q_head,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output sacf_pkg::rsp_t rsp
);
	import sacf_pkg::*;

	localparam int OFFW = $clog2(LINE_BYTES);
	localparam int SETB = $clog2(SETS);
	localparam int SETW = (SETS > 1) ? SETB : 1;
	localparam int WAYW = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int TAGW = ADDR_W - OFFW - SETB;

	// one row per set: tags, valid, dirty and the oldest-way pointer
	logic [WAYS-1:0][TAGW-1:0] tag_mem   [SETS];
	logic [WAYS-1:0]           valid_mem [SETS];
	logic [WAYS-1:0]           dirty_mem [SETS];
	logic [WAYW-1:0]           old_mem   [SETS];

	logic [WAYS-1:0][TAGW-1:0] tag_rd_q, tag_wd;
	logic [WAYS-1:0]           valid_rd_q, valid_wd, dirty_rd_q, dirty_wd;
	logic [WAYW-1:0]           old_rd_q, old_wd;

	back_state_t   st_q, st_n;
	logic [SETW-1:0] clr_q;
	logic          mem_re, mem_we, step;
	logic [SETW-1:0] ra, wa, cur_set;
	req_t          cur_s1;
	logic [TAGW-1:0] cur_tag;

	logic [WAYS-1:0] hit_vec;
	logic            found, wb, wr;
	logic [WAYW-1:0] fw, victim;

	cnt_t rd_cnt_q, wr_cnt_q, rd_miss_q, wr_miss_q, rd_byte_q, wr_byte_q, evict_q;
	cnt_t rd_cnt_n, wr_cnt_n, rd_miss_n, wr_miss_n, rd_byte_n, wr_byte_n, evict_n;

	logic rsp_valid_q;
	rsp_t rsp_q, rsp_n;
	logic out_free;

	function automatic logic [SETW-1:0] set_of(logic [ADDR_W-1:0] a);
		return (SETS > 1) ? SETW'(a >> OFFW) : '0;
	endfunction

	assign ra      = set_of(q_head.address);
	assign cur_set = set_of(cur_s1.address);
	assign cur_tag = TAGW'(cur_s1.address >> (OFFW + SETB));
	assign wr      = (cur_s1.operation == OP_WRITE);

	// lookup on the registered row
	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			hit_vec[w] = valid_rd_q[w] && (tag_rd_q[w] == cur_tag);
		end
		found = |hit_vec;
		fw    = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (hit_vec[w]) begin
				fw = WAYW'(w);
			end
		end
	end

	assign victim = old_rd_q;
	assign wb     = !found && valid_rd_q[victim] && dirty_rd_q[victim];

	assign out_free = !rsp_valid_q || !rsp_stall;

	always_comb begin
		st_n     = st_q;
		mem_re   = 1'b0;
		mem_we   = 1'b0;
		q_pop    = 1'b0;
		step     = 1'b0;
		wa       = cur_set;
		tag_wd   = tag_rd_q;
		valid_wd = valid_rd_q;
		dirty_wd = dirty_rd_q;
		old_wd   = old_rd_q;
		case (st_q)
			BK_CLEAR: begin
				mem_we   = 1'b1;
				wa       = clr_q;
				tag_wd   = '0;
				valid_wd = '0;
				dirty_wd = '0;
				old_wd   = '0;
				if (clr_q == SETW'(SETS - 1)) begin
					st_n = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (q_valid) begin
					mem_re = 1'b1;
					q_pop  = 1'b1;
					st_n   = BK_LOOKUP;
				end
			end
			BK_LOOKUP: begin
				if (out_free) begin
					mem_we = 1'b1;
					step   = 1'b1;
					st_n   = BK_IDLE;
					if (found) begin
						if (wr) begin
							dirty_wd[fw] = 1'b1;
						end
					end else begin
						tag_wd[victim]   = cur_tag;
						valid_wd[victim] = 1'b1;
						dirty_wd[victim] = wr;
						old_wd = (victim == WAYW'(WAYS - 1)) ? '0 : victim + 1'b1;
					end
				end
			end
			default: begin
				st_n = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= BK_CLEAR;
			clr_q <= '0;
		end else begin
			st_q <= st_n;
			if (st_q == BK_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			tag_mem[wa]   <= tag_wd;
			valid_mem[wa] <= valid_wd;
			dirty_mem[wa] <= dirty_wd;
			old_mem[wa]   <= old_wd;
		end
		if (mem_re) begin
			tag_rd_q   <= tag_mem[ra];
			valid_rd_q <= valid_mem[ra];
			dirty_rd_q <= dirty_mem[ra];
			old_rd_q   <= old_mem[ra];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_s1 <= q_head;
		end
	end

	// statistics
	always_comb begin
		rd_cnt_n  = wr ? rd_cnt_q  : sat_add(rd_cnt_q, BYTES_W'(1));
		rd_byte_n = wr ? rd_byte_q : sat_add(rd_byte_q, cur_s1.access_bytes);
		wr_cnt_n  = wr ? sat_add(wr_cnt_q, BYTES_W'(1))         : wr_cnt_q;
		wr_byte_n = wr ? sat_add(wr_byte_q, cur_s1.access_bytes) : wr_byte_q;
		rd_miss_n = (!found && !wr) ? sat_add(rd_miss_q, BYTES_W'(1)) : rd_miss_q;
		wr_miss_n = (!found && wr)  ? sat_add(wr_miss_q, BYTES_W'(1)) : wr_miss_q;
		evict_n   = wb ? sat_add(evict_q, BYTES_W'(1)) : evict_q;
	end

	always_comb begin
		rsp_n.hit             = found;
		rsp_n.writeback_valid = wb;
		rsp_n.writeback_address = wb ?
			((ADDR_W'(tag_rd_q[victim]) << (OFFW + SETB)) | (ADDR_W'(cur_set) << OFFW)) : '0;
		rsp_n.fill_address = found ? '0 : ((cur_s1.address >> OFFW) << OFFW);
		rsp_n.read_accesses_total  = rd_cnt_n;
		rsp_n.write_accesses_total = wr_cnt_n;
		rsp_n.read_misses_total    = rd_miss_n;
		rsp_n.write_misses_total   = wr_miss_n;
		rsp_n.bytes_read_total     = rd_byte_n;
		rsp_n.bytes_written_total  = wr_byte_n;
		rsp_n.writebacks_total     = evict_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q    <= '0;
			wr_cnt_q    <= '0;
			rd_miss_q   <= '0;
			wr_miss_q   <= '0;
			rd_byte_q   <= '0;
			wr_byte_q   <= '0;
			evict_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (step) begin
				rd_cnt_q    <= rd_cnt_n;
				wr_cnt_q    <= wr_cnt_n;
				rd_miss_q   <= rd_miss_n;
				wr_miss_q   <= wr_miss_n;
				rd_byte_q   <= rd_byte_n;
				wr_byte_q   <= wr_byte_n;
				evict_q     <= evict_n;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			rsp_q <= rsp_n;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== hw/rtl/set_assoc_cache_fifo_tags_core.sv =====
// a beat passes the queue, the set row read register, then the result register
// each access reads then writes its set row; no new beat is popped until the write
// the front queue holds two beats, so it can take up to two while a result is stalled
// reset: asynchronous; a clearing pass then sweeps every set row,
// and no result comes out until it ends (beats still queue up meanwhile)
`include "set_assoc_cache_fifo_tags_core_macros.svh"

module set_assoc_cache_fifo_tags_core #(
	parameter int SETS       = 64,
	parameter int WAYS       = 4,
	parameter int LINE_BYTES = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  sacf_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output sacf_pkg::rsp_t rsp
);
	import sacf_pkg::*;

	logic q_valid, q_pop;
	req_t q_head;

	sacf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_head    (q_head)
	);

	sacf_back #(
		.SETS       (SETS),
		.WAYS       (WAYS),
		.LINE_BYTES (LINE_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_head    (q_head),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	`SACF_ASSERT_NOW(a_pop_needs_item, q_pop, q_valid, "pop from empty queue")
	`SACF_ASSERT_NOW(a_hit_no_fill, rsp_valid && rsp.hit, (rsp.fill_address == '0) && !rsp.writeback_valid, "hit with fill or writeback")
	`SACF_ASSERT_NOW(a_no_wb_addr_zero, rsp_valid && !rsp.writeback_valid, rsp.writeback_address == '0, "writeback address without writeback")
	`SACF_ASSERT_NEXT(a_pop_no_double, q_pop, !q_pop, "back end popped two cycles in a row")

endmodule
